// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the triangle index generator.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/gtig_pkg.sv
// Types, codes and offset tables for the grid triangle index generator.
// No dependencies; used by the result channel interface and the top level.
package gtig_pkg;

  // Vertex index as delivered on the result channel
  typedef logic [12:0] idx_t;

  // Six corner offsets of one triangle: row, column for each of three vertices
  typedef logic [1:0]      ofs_t;
  typedef ofs_t [0:5]      ofs_row_t;

  // Simplified list sections
  localparam logic [2:0] PH_CORNER = 3'd0;
  localparam logic [2:0] PH_INNER  = 3'd1;
  localparam logic [2:0] PH_SIDE_B = 3'd2;
  localparam logic [2:0] PH_SIDE_A = 3'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DIVISIONS  = 2'd0;
  localparam logic [1:0] REG_POS_FACE   = 2'd1;
  localparam logic [1:0] REG_SIMPLIFIED = 2'd2;

  // Detailed list, two triangles per cell
  localparam ofs_row_t DET_TAB [0:1] = '{
    {2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0},
    {2'd1, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0}};

  // Corner cells
  localparam ofs_row_t CORNER_TAB [0:1] = '{
    {2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1},
    {2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1}};

  // Merged double cells
  localparam ofs_row_t INNER_TAB [0:1] = '{
    {2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2},
    {2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2}};

  // Stitches along the column axis
  localparam ofs_row_t SIDE_B_TAB [0:5] = '{
    {2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0},
    {2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1},
    {2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1},
    {2'd1, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0},
    {2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0},
    {2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2}};

  // Stitches along the row axis
  localparam ofs_row_t SIDE_A_TAB [0:5] = '{
    {2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0},
    {2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd1},
    {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0},
    {2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1},
    {2'd0, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1},
    {2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1}};

endpackage

// File: rtl/gtig_if.sv
// Valid/ready channel interfaces for requests and triangle results.
// Depends on gtig_pkg for the index type.
interface gtig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface gtig_out_if import gtig_pkg::*;;
  logic valid;
  logic ready;
  idx_t first_index;
  idx_t second_index;
  idx_t third_index;
  logic last_triangle;
  logic valid_res;

  modport source (output valid, output first_index, output second_index,
                  output third_index, output last_triangle, output valid_res,
                  input ready);
  modport sink   (input valid, input first_index, input second_index,
                  input third_index, input last_triangle, input valid_res,
                  output ready);
endinterface

// File: rtl/grid_triangle_index_generator_unit.sv
// Pipeline: an accepted request's operands are registered in stage one (op_r) and
// its triangle in stage two (first_r, second_r, third_r) for the result ports.
// Throughput: one request per cycle while the result channel is ready; the walk counters step at acceptance and
// the three index multiplies sit in the second stage.
// Reset (rst_n, synchronous, active low): divisions 16, positive face,
// detailed list; the list reads finished until a restart request.
`include "assert_macros.svh"

module grid_triangle_index_generator_unit import gtig_pkg::*; #(
  parameter int MAX_DIVISIONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  gtig_in_if.sink           in_chan,
  gtig_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [6:0] MaxDivEven = 7'(MAX_DIVISIONS) & 7'h7E;

  // Operands for the index stage
  typedef struct packed {
    logic     emit;
    logic     last;
    logic     face;
    logic [7:0] a;
    logic [7:0] b;
    logic [6:0] p;
    ofs_row_t ofs;
  } op_t;

  // Configuration registers
  logic [6:0] divisions_r;
  logic       positive_face_r;
  logic       simplified_r;

  // Walk state
  logic [2:0] phase_r,  phase_nxt;
  logic [6:0] row_r,    row_nxt;
  logic [6:0] col_r,    col_nxt;
  logic [2:0] sub_r,    sub_nxt;
  logic       fin_r,    fin_nxt;

  // Pipeline
  logic s1_valid_r, s2_valid_r;
  op_t  op_r, op_nxt;
  idx_t first_r, second_r, third_r;
  logic last_r, vres_r;
  logic s2_adv, in_acc;
  idx_t first_nxt_c, second_nxt_c, third_nxt_c;

  // Configuration port: always ready, write on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisions_r     <= 7'd16;
      positive_face_r <= 1'b1;
      simplified_r    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DIVISIONS:  divisions_r     <= pwdata[6:0];
        REG_POS_FACE:   positive_face_r <= pwdata[0];
        REG_SIMPLIFIED: simplified_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIVISIONS:  prdata = {25'd0, divisions_r};
      REG_POS_FACE:   prdata = {31'd0, positive_face_r};
      REG_SIMPLIFIED: prdata = {31'd0, simplified_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Handshake: stage two drains when empty or taken, stage one follows
  assign s2_adv        = !s2_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s2_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Walk step: pick operands for the current triangle and advance
  always_comb begin
    logic [6:0] d, dm1, s, cols_lim, rows_lim;
    logic [2:0] ph, sub, sel6, subs_lim, sub1;
    logic [6:0] row, col, col1, row1;
    logic       fin, wrap;

    d = divisions_r & 7'h7E;
    if (d < 7'd2) d = 7'd2;
    if (d > MaxDivEven) d = MaxDivEven;
    dm1 = d - 7'd1;
    s   = {1'b0, d[6:1]} - 7'd1;

    // Restart clears the walk
    ph  = in_chan.restart ? PH_CORNER : phase_r;
    row = in_chan.restart ? 7'd0 : row_r;
    col = in_chan.restart ? 7'd0 : col_r;
    sub = in_chan.restart ? 3'd0 : sub_r;
    fin = in_chan.restart ? 1'b0 : fin_r;

    sel6 = (sub < 3'd6) ? sub : 3'd5;

    op_nxt.p    = d + 7'd1;
    op_nxt.face = positive_face_r;
    op_nxt.emit = !fin;

    // Operands and walk limits per section
    if (!simplified_r) begin
      op_nxt.a   = {1'b0, row};
      op_nxt.b   = {1'b0, col};
      op_nxt.ofs = DET_TAB[sub[0]];
      subs_lim = 3'd2; cols_lim = d; rows_lim = d;
    end else begin
      unique case (ph)
        PH_CORNER: begin
          op_nxt.a   = (row != 7'd0) ? {1'b0, dm1} : 8'd0;
          op_nxt.b   = (col != 7'd0) ? {1'b0, dm1} : 8'd0;
          op_nxt.ofs = CORNER_TAB[sub[0]];
          subs_lim = 3'd2; cols_lim = 7'd2; rows_lim = 7'd2;
        end
        PH_INNER: begin
          op_nxt.a   = {row, 1'b1};
          op_nxt.b   = {col, 1'b1};
          op_nxt.ofs = INNER_TAB[sub[0]];
          subs_lim = 3'd2; cols_lim = s; rows_lim = s;
        end
        PH_SIDE_B: begin
          op_nxt.a   = (sub < 3'd3) ? 8'd0 : {1'b0, dm1};
          op_nxt.b   = {row, 1'b1};
          op_nxt.ofs = SIDE_B_TAB[sel6];
          subs_lim = 3'd6; cols_lim = 7'd1; rows_lim = s;
        end
        default: begin
          op_nxt.a   = {row, 1'b1};
          op_nxt.b   = (sub < 3'd3) ? 8'd0 : {1'b0, dm1};
          op_nxt.ofs = SIDE_A_TAB[sel6];
          subs_lim = 3'd6; cols_lim = 7'd1; rows_lim = s;
        end
      endcase
    end

    // Advance triangle, column, row
    sub1 = sub + 3'd1;
    col1 = col + 7'd1;
    row1 = row + 7'd1;
    wrap = 1'b0;
    sub_nxt = sub; col_nxt = col; row_nxt = row;
    if (sub1 < subs_lim) begin
      sub_nxt = sub1;
    end else begin
      sub_nxt = 3'd0;
      if (col1 < cols_lim) begin
        col_nxt = col1;
      end else begin
        col_nxt = 7'd0;
        if (row1 < rows_lim) begin
          row_nxt = row1;
        end else begin
          row_nxt = 7'd0;
          wrap    = 1'b1;
        end
      end
    end

    // Section change or end of list on wrap
    phase_nxt = ph;
    fin_nxt   = fin;
    if (wrap) begin
      if (!simplified_r) begin
        fin_nxt = 1'b1;
      end else begin
        unique case (ph)
          PH_CORNER: begin
            if (s == 7'd0) fin_nxt = 1'b1;
            else           phase_nxt = PH_INNER;
          end
          PH_INNER:  phase_nxt = PH_SIDE_B;
          PH_SIDE_B: phase_nxt = PH_SIDE_A;
          default:   fin_nxt = 1'b1;
        endcase
      end
    end

    // A finished list holds its state
    if (fin) begin
      sub_nxt = sub; col_nxt = col; row_nxt = row;
      phase_nxt = ph; fin_nxt = fin;
    end
    op_nxt.last = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CORNER;
      row_r   <= 7'd0;
      col_r   <= 7'd0;
      sub_r   <= 3'd0;
      fin_r   <= 1'b1;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      sub_r   <= sub_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Stage one: hold operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) op_r <= op_nxt;
  end

  // Stage two: vertex index = (a + dr) * p + (b + dc), three in parallel
  always_comb begin
    logic [8:0]  ra, cb;
    logic [15:0] prod;
    idx_t        idx [0:2];
    for (int k = 0; k < 3; k++) begin
      ra     = {1'b0, op_r.a} + {7'd0, op_r.ofs[2*k]};
      cb     = {1'b0, op_r.b} + {7'd0, op_r.ofs[2*k+1]};
      prod   = 16'(ra) * 16'(op_r.p);
      idx[k] = 13'(prod + 16'(cb));
    end
    first_nxt_c  = op_r.face ? idx[0] : idx[2];
    second_nxt_c = idx[1];
    third_nxt_c  = op_r.face ? idx[2] : idx[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Drop the indices of a finished-list request
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      first_r  <= op_r.emit ? first_nxt_c  : '0;
      second_r <= op_r.emit ? second_nxt_c : '0;
      third_r  <= op_r.emit ? third_nxt_c  : '0;
      last_r   <= op_r.emit && op_r.last;
      vres_r   <= op_r.emit;
    end
  end

  assign out_chan.valid         = s2_valid_r;
  assign out_chan.first_index   = first_r;
  assign out_chan.second_index  = second_r;
  assign out_chan.third_index   = third_r;
  assign out_chan.last_triangle = last_r;
  assign out_chan.valid_res     = vres_r;

  // Checks
  `ASSERT_IMPL(a_empty_ready, clk, rst_n, !s2_valid_r, in_chan.ready)
  `ASSERT_IMPL(a_idle_zero, clk, rst_n, out_chan.valid && !out_chan.valid_res,
    out_chan.first_index == 13'd0 && out_chan.third_index == 13'd0 && !out_chan.last_triangle)
  `ASSERT_NEXT(a_fin_no_emit, clk, rst_n, in_acc && fin_r && !in_chan.restart,
    s1_valid_r && !op_r.emit)
  `ASSERT_NEXT(a_last_sets_fin, clk, rst_n, in_acc && op_nxt.emit && op_nxt.last, fin_r)

endmodule
